>>> design/smx_pkg.sv
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants of the stack machine executor
// Stack geometry, opcodes, status codes, controller and ALU states and
// the command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package smx_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 256;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // instruction opcodes; every other code is unknown
  typedef enum logic [3:0] {
    OP_HALT = 4'd0,
    OP_CALL = 4'd1,
    OP_PUSH = 4'd2,
    OP_MOVE = 4'd3,
    OP_POP  = 4'd4,
    OP_ADD  = 4'd5,
    OP_SUB  = 4'd6,
    OP_MUL  = 4'd7,
    OP_DIV  = 4'd8
  } op_t;

  // result status codes
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_HALTED    = 4'd1,
    ST_UNDERFLOW = 4'd2,
    ST_NOT_INT   = 4'd3,
    ST_BAD_ADDR  = 4'd4,
    ST_UNKNOWN   = 4'd5,
    ST_OVERFLOW  = 4'd6,
    ST_DIV_ZERO  = 4'd7,
    ST_BAD_FUNC  = 4'd8,
    ST_IGNORED   = 4'd9
  } status_t;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_ARB,
    S_ALU,
    S_NEWTOP_RD,
    S_NEWTOP,
    S_OUT
  } ctrl_state_t;

  // arithmetic unit states
  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_MUL,
    ALU_DIV,
    ALU_FIX
  } alu_state_t;

  // controller to datapath
  typedef struct packed {
    logic    load_instr;
    logic    push;
    logic    pop;
    logic    move;
    logic    arith_wr;
    logic    rd_nos;
    logic    rd_top;
    logic    load_top;
    logic    alu_start;
    logic    load_out;
    status_t status;
    logic    call;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] mode;
    logic       oint;
    logic       depth_zero;
    logic       depth_lt2;
    logic       depth_full;
    logic       call_ok;
    logic       move_ok;
    logic       a_int;
    logic       b_int;
    logic       a_zero;
    logic       alu_done;
  } dp_stat_t;

endpackage

>>> design/smx_if.sv
// ----------------------------------------------------------------------------
// smx_if: channel interfaces of the stack machine executor
// Instruction input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface smx_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [63:0] operand;
  logic               operand_is_integer;

  modport source (output valid, output mode, output operand, output operand_is_integer,
                  input ready);
  modport sink (input valid, input mode, input operand, input operand_is_integer,
                output ready);
endinterface

interface smx_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         status;
  logic [8:0]         depth;
  logic signed [63:0] top_value;
  logic               top_is_integer;
  logic               call_request;
  logic [7:0]         call_index;

  modport source (output valid, output status, output depth, output top_value,
                  output top_is_integer, output call_request, output call_index,
                  input ready);
  modport sink (input valid, input status, input depth, input top_value,
                input top_is_integer, input call_request, input call_index,
                output ready);
endinterface

interface smx_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] library_size;

  modport source (output valid, output library_size, input ready);
  modport sink (input valid, input library_size, output ready);
endinterface

>>> design/smx_alu.sv
// ----------------------------------------------------------------------------
// smx_alu: arithmetic unit
// Add and subtract with a registered result, multiply from 32x32 partial
// products, divide by a restoring loop of one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smx_alu (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  smx_pkg::op_t  op,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic          done,
  output logic [63:0]   result
);

  smx_pkg::alu_state_t state_r, state_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] res_r, res_nxt;
  logic        neg_r, neg_nxt;

  logic [31:0] mul_x, mul_y;
  logic [64:0] shifted, diff;

  // next state and datapath of the unit
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    rem_nxt   = rem_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;
    neg_nxt   = neg_r;
    mul_x     = a_r[31:0];
    mul_y     = b_r[31:0];
    shifted   = {rem_r, b_r[63]};
    diff      = shifted - {1'b0, a_r};

    case (state_r)
      smx_pkg::ALU_IDLE: begin
        if (start) begin
          cnt_nxt = '0;
          case (op)
            smx_pkg::OP_ADD: begin
              res_nxt  = b + a;
              done_nxt = 1'b1;
            end
            smx_pkg::OP_SUB: begin
              res_nxt  = b - a;
              done_nxt = 1'b1;
            end
            smx_pkg::OP_MUL: begin
              a_nxt     = a;
              b_nxt     = b;
              state_nxt = smx_pkg::ALU_MUL;
            end
            smx_pkg::OP_DIV: begin
              // magnitudes; the most negative value stays 2^63 unsigned
              a_nxt     = a[63] ? (64'd0 - a) : a;
              b_nxt     = b[63] ? (64'd0 - b) : b;
              rem_nxt   = '0;
              neg_nxt   = a[63] ^ b[63];
              state_nxt = smx_pkg::ALU_DIV;
            end
            default: begin
              res_nxt  = '0;
              done_nxt = 1'b1;
            end
          endcase
        end
      end

      // low word of the product: lo*lo + (lo*hi + hi*lo) << 32
      smx_pkg::ALU_MUL: begin
        cnt_nxt = cnt_r + 6'd1;
        case (cnt_r[1:0])
          2'd0: begin
            mul_x = a_r[31:0];
            mul_y = b_r[31:0];
          end
          2'd1: begin
            mul_x   = a_r[31:0];
            mul_y   = b_r[63:32];
            res_nxt = prod_r;
          end
          2'd2: begin
            mul_x   = a_r[63:32];
            mul_y   = b_r[31:0];
            res_nxt = res_r + {prod_r[31:0], 32'd0};
          end
          default: begin
            res_nxt   = res_r + {prod_r[31:0], 32'd0};
            done_nxt  = 1'b1;
            state_nxt = smx_pkg::ALU_IDLE;
          end
        endcase
        prod_nxt = 64'(mul_x) * 64'(mul_y);
      end

      // one quotient bit per cycle, dividend shifts out of b_r
      smx_pkg::ALU_DIV: begin
        cnt_nxt = cnt_r + 6'd1;
        if (!diff[64]) begin
          rem_nxt = diff[63:0];
          b_nxt   = {b_r[62:0], 1'b1};
        end else begin
          rem_nxt = shifted[63:0];
          b_nxt   = {b_r[62:0], 1'b0};
        end
        if (&cnt_r) begin
          state_nxt = smx_pkg::ALU_FIX;
        end
      end

      // sign of the quotient
      smx_pkg::ALU_FIX: begin
        res_nxt   = neg_r ? (64'd0 - b_r) : b_r;
        done_nxt  = 1'b1;
        state_nxt = smx_pkg::ALU_IDLE;
      end

      default: begin
        state_nxt = smx_pkg::ALU_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= smx_pkg::ALU_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
    res_r  <= res_nxt;
    neg_r  <= neg_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

  // a new operation only starts on an idle unit
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == smx_pkg::ALU_IDLE)
    else $error("alu started while busy");

  // done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("alu done held for more than one cycle");

endmodule

>>> design/smx_dp.sv
// ----------------------------------------------------------------------------
// smx_dp: datapath of the stack machine executor
// Instruction register, stack memory with a cached top entry, depth counter,
// library size register, arithmetic unit and the result register.
// ----------------------------------------------------------------------------
module smx_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  smx_pkg::dp_cmd_t  cmd,
  output smx_pkg::dp_stat_t stat,
  input  logic [3:0]        in_mode,
  input  logic [63:0]       in_operand,
  input  logic              in_operand_is_integer,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_library_size,
  output logic [3:0]        out_status,
  output logic [8:0]        out_depth,
  output logic [63:0]       out_top_value,
  output logic              out_top_is_integer,
  output logic              out_call_request,
  output logic [7:0]        out_call_index
);

  localparam int AW = smx_pkg::ADDR_W;
  localparam int CW = smx_pkg::CNT_W;

  // stack memory: value with its integer tag in bit 64
  logic [64:0] mem [smx_pkg::STACK_DEPTH];
  logic [64:0] rd_r;

  logic [3:0]  mode_r;
  logic [63:0] opnd_r;
  logic        oint_r;
  logic [7:0]  lib_r;
  logic [CW-1:0] depth_r, depth_nxt;
  logic [63:0] top_val_r, top_val_nxt;
  logic        top_int_r, top_int_nxt;

  logic [3:0]  out_status_r;
  logic [8:0]  out_depth_r;
  logic [63:0] out_top_r;
  logic        out_top_int_r;
  logic        out_creq_r;
  logic [7:0]  out_cidx_r;

  logic [CW-1:0] depth_m1, depth_m2, rsel;
  logic [CW+8:0] depth_ext;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [64:0]   wdata;
  logic [63:0]   alu_res;
  logic          alu_done;

  assign depth_m1  = depth_r - CW'(1);
  assign depth_m2  = depth_r - CW'(2);
  assign depth_ext = {9'd0, depth_r};

  // arithmetic unit: a is the top entry, b the one below it
  smx_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.alu_start),
    .op     (smx_pkg::op_t'(mode_r)),
    .a      (top_val_r),
    .b      (rd_r[63:0]),
    .done   (alu_done),
    .result (alu_res)
  );

  // memory port selection
  always_comb begin
    we    = cmd.push | cmd.move | cmd.arith_wr;
    waddr = depth_r[AW-1:0];
    wdata = {oint_r, opnd_r};
    if (cmd.move) begin
      waddr = opnd_r[AW-1:0];
      wdata = {top_int_r, top_val_r};
    end else if (cmd.arith_wr) begin
      waddr = depth_m2[AW-1:0];
      wdata = {1'b1, alu_res};
    end
    re    = cmd.rd_nos | cmd.rd_top;
    rsel  = cmd.rd_nos ? depth_m2 : depth_m1;
    raddr = rsel[AW-1:0];
  end

  // depth and cached top entry
  always_comb begin
    depth_nxt   = depth_r;
    top_val_nxt = top_val_r;
    top_int_nxt = top_int_r;
    if (cmd.push) begin
      depth_nxt   = depth_r + CW'(1);
      top_val_nxt = opnd_r;
      top_int_nxt = oint_r;
    end else if (cmd.pop | cmd.move) begin
      depth_nxt = depth_m1;
    end else if (cmd.arith_wr) begin
      depth_nxt   = depth_m1;
      top_val_nxt = alu_res;
      top_int_nxt = 1'b1;
    end else if (cmd.load_top) begin
      top_val_nxt = rd_r[63:0];
      top_int_nxt = rd_r[64];
    end
  end

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_r <= mem[raddr];
    end
  end

  // control state of the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
      lib_r   <= 8'd1;
    end else begin
      depth_r <= depth_nxt;
      if (cfg_we) begin
        lib_r <= cfg_library_size;
      end
    end
  end

  // instruction, top and result words
  always_ff @(posedge clk) begin
    top_val_r <= top_val_nxt;
    top_int_r <= top_int_nxt;
    if (cmd.load_instr) begin
      mode_r <= in_mode;
      opnd_r <= in_operand;
      oint_r <= in_operand_is_integer;
    end
    if (cmd.load_out) begin
      out_status_r  <= cmd.status;
      out_depth_r   <= depth_ext[8:0];
      out_top_r     <= (depth_r == '0) ? 64'd0 : top_val_r;
      out_top_int_r <= (depth_r == '0) ? 1'b0 : top_int_r;
      out_creq_r    <= cmd.call;
      out_cidx_r    <= cmd.call ? opnd_r[7:0] : 8'd0;
    end
  end

  // status towards the controller
  always_comb begin
    stat.mode       = mode_r;
    stat.oint       = oint_r;
    stat.depth_zero = (depth_r == '0);
    stat.depth_lt2  = (depth_r < CW'(2));
    stat.depth_full = (depth_r == CW'(smx_pkg::STACK_DEPTH));
    stat.call_ok    = !opnd_r[63] && (opnd_r < 64'(lib_r));
    stat.move_ok    = !opnd_r[63] && (opnd_r < 64'(depth_m1));
    stat.a_int      = top_int_r;
    stat.b_int      = rd_r[64];
    stat.a_zero     = (top_val_r == 64'd0);
    stat.alu_done   = alu_done;
  end

  assign out_status         = out_status_r;
  assign out_depth          = out_depth_r;
  assign out_top_value      = out_top_r;
  assign out_top_is_integer = out_top_int_r;
  assign out_call_request   = out_creq_r;
  assign out_call_index     = out_cidx_r;

endmodule

>>> design/smx_ctrl.sv
// ----------------------------------------------------------------------------
// smx_ctrl: controller of the stack machine executor
// Sequences each instruction through checks, memory accesses and the
// arithmetic unit, holds the stopped flag and the result valid.
// ----------------------------------------------------------------------------
module smx_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  smx_pkg::dp_stat_t stat,
  output smx_pkg::dp_cmd_t  cmd
);

  smx_pkg::ctrl_state_t state_r, state_nxt;
  logic              stopped_r, stopped_nxt;
  logic              out_valid_r, out_valid_nxt;
  smx_pkg::status_t  status_r, status_nxt;
  logic              call_r, call_nxt;

  // every status but ok and unknown opcode halts execution
  function automatic logic stops(smx_pkg::status_t s);
    stops = (s != smx_pkg::ST_OK) && (s != smx_pkg::ST_UNKNOWN);
  endfunction

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    stopped_nxt = stopped_r;
    status_nxt  = status_r;
    call_nxt    = call_r;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.status  = status_r;
    cmd.call    = call_r;

    case (state_r)
      smx_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_instr = 1'b1;
          state_nxt      = smx_pkg::S_EXEC;
        end
      end

      smx_pkg::S_EXEC: begin
        status_nxt = smx_pkg::ST_OK;
        call_nxt   = 1'b0;
        state_nxt  = smx_pkg::S_OUT;
        if (stopped_r) begin
          status_nxt = smx_pkg::ST_IGNORED;
        end else begin
          case (stat.mode)
            smx_pkg::OP_HALT: begin
              status_nxt = smx_pkg::ST_HALTED;
            end
            smx_pkg::OP_CALL: begin
              if (!stat.oint) begin
                status_nxt = smx_pkg::ST_NOT_INT;
              end else if (!stat.call_ok) begin
                status_nxt = smx_pkg::ST_BAD_FUNC;
              end else begin
                call_nxt = 1'b1;
              end
            end
            smx_pkg::OP_PUSH: begin
              if (stat.depth_full) begin
                status_nxt = smx_pkg::ST_OVERFLOW;
              end else begin
                cmd.push = 1'b1;
              end
            end
            smx_pkg::OP_MOVE: begin
              if (!stat.oint) begin
                status_nxt = smx_pkg::ST_BAD_ADDR;
              end else if (stat.depth_zero) begin
                status_nxt = smx_pkg::ST_UNDERFLOW;
              end else if (!stat.move_ok) begin
                status_nxt = smx_pkg::ST_BAD_ADDR;
              end else begin
                cmd.move  = 1'b1;
                state_nxt = smx_pkg::S_NEWTOP_RD;
              end
            end
            smx_pkg::OP_POP: begin
              if (stat.depth_zero) begin
                status_nxt = smx_pkg::ST_UNDERFLOW;
              end else begin
                cmd.pop   = 1'b1;
                state_nxt = smx_pkg::S_NEWTOP_RD;
              end
            end
            smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL, smx_pkg::OP_DIV: begin
              if (stat.depth_lt2) begin
                status_nxt = smx_pkg::ST_UNDERFLOW;
              end else begin
                cmd.rd_nos = 1'b1;
                state_nxt  = smx_pkg::S_ARB;
              end
            end
            default: begin
              status_nxt = smx_pkg::ST_UNKNOWN;
            end
          endcase
        end
      end

      // second operand now in the read register
      smx_pkg::S_ARB: begin
        if (!stat.a_int || !stat.b_int) begin
          status_nxt = smx_pkg::ST_NOT_INT;
          state_nxt  = smx_pkg::S_OUT;
        end else if ((stat.mode == smx_pkg::OP_DIV) && stat.a_zero) begin
          status_nxt = smx_pkg::ST_DIV_ZERO;
          state_nxt  = smx_pkg::S_OUT;
        end else begin
          cmd.alu_start = 1'b1;
          state_nxt     = smx_pkg::S_ALU;
        end
      end

      smx_pkg::S_ALU: begin
        if (stat.alu_done) begin
          cmd.arith_wr = 1'b1;
          state_nxt    = smx_pkg::S_OUT;
        end
      end

      // refetch the new top entry after a pop or move
      smx_pkg::S_NEWTOP_RD: begin
        if (stat.depth_zero) begin
          state_nxt = smx_pkg::S_OUT;
        end else begin
          cmd.rd_top = 1'b1;
          state_nxt  = smx_pkg::S_NEWTOP;
        end
      end

      smx_pkg::S_NEWTOP: begin
        cmd.load_top = 1'b1;
        state_nxt    = smx_pkg::S_OUT;
      end

      // hand the word to the result register once it is free
      smx_pkg::S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          stopped_nxt  = stopped_r | stops(status_r);
          state_nxt    = smx_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = smx_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt = (out_valid_r && !out_ready) || cmd.load_out;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smx_pkg::S_IDLE;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // status of the instruction in flight
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    call_r   <= call_nxt;
  end

  assign out_valid = out_valid_r;

  // once stopped, only reset restarts the block
  a_stopped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r)
    else $error("stopped flag cleared without reset");

  // a stopped block reports every word as ignored
  a_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_out && stopped_r) |-> (status_r == smx_pkg::ST_IGNORED))
    else $error("stopped block reported a status other than ignored");

  // an accepted word goes straight to execution
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == smx_pkg::S_EXEC))
    else $error("accepted word did not enter execution");

endmodule

>>> design/stack_machine_executor_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_executor_unit: stack machine instruction executor
// Top level joining the controller and the datapath to the channels.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries one instruction per word (mode, operand, integer tag).
//   out_ch returns exactly one result word per instruction, in order:
//          status, stack depth, top entry and any library call request.
//   cfg_ch writes library_size; it is always ready, write it while idle.
// Sequence of controller states per word:
//   halt, call, push, unknown opcode, ignored word, decode errors: exec, out
//   pop, move: exec, newtop read, newtop, out; a pop that empties the stack
//     skips the re-read of the new top
//   add, sub, mul (four 32x32 partial-product steps): exec, arb, alu, out
//   div: exec, arb, alu, out (restoring divider, one quotient bit per cycle)
//   non-integer operand or zero divisor on arithmetic: exec, arb, out
//   The next word is accepted the cycle after the result is registered;
//   the stack memory has a write port and a registered read port.
// Reset: synchronous, active low; the stack empties, library_size returns
//   to 1 and the stopped flag clears. No clearing pass is needed.
// Stall: the result register holds while out_ch.ready is low; one more
//   instruction is accepted and executed, then waits for the register.
// ----------------------------------------------------------------------------
module stack_machine_executor_unit (
  input  logic       clk,
  input  logic       rst_n,
  smx_in_if.sink     in_ch,
  smx_out_if.source  out_ch,
  smx_cfg_if.sink    cfg_ch
);

  smx_pkg::dp_cmd_t  cmd;
  smx_pkg::dp_stat_t stat;
  logic [63:0]       top_value;

  // configuration is taken every cycle
  assign cfg_ch.ready = 1'b1;

  smx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  smx_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .stat                  (stat),
    .in_mode               (in_ch.mode),
    .in_operand            (in_ch.operand),
    .in_operand_is_integer (in_ch.operand_is_integer),
    .cfg_we                (cfg_ch.valid),
    .cfg_library_size      (cfg_ch.library_size),
    .out_status            (out_ch.status),
    .out_depth             (out_ch.depth),
    .out_top_value         (top_value),
    .out_top_is_integer    (out_ch.top_is_integer),
    .out_call_request      (out_ch.call_request),
    .out_call_index        (out_ch.call_index)
  );

  assign out_ch.top_value = signed'(top_value);

endmodule
